// ----- hdl/lsq_pkg.sv -----
`default_nettype none
package lsq_pkg;

  localparam int ROWS = 64;
  localparam int COLS = 64;
  localparam int FIELD_W = 7;
  localparam int ROW_AW = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int COL_AW = (COLS > 1) ? $clog2(COLS) : 1;
  localparam int CFG_IDX_W = 2;

  localparam logic [CFG_IDX_W-1:0] CFG_ROWS_USED = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS_USED = 2'd1;

  localparam logic FUNC_TOGGLE = 1'b0;
  localparam logic FUNC_QUERY  = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE,
    S_TGL_RD,
    S_TGL_WR,
    S_ROW_RD,
    S_ROW_WAIT,
    S_COL_RD,
    S_COL_CALC,
    S_DONE
  } state_e;

  typedef struct packed {
    logic               is_one;
    logic [FIELD_W-1:0] up;
    logic [FIELD_W-1:0] left;
    logic [FIELD_W-1:0] diag;
    logic [FIELD_W-1:0] best;
  } dp_in_t;

  typedef struct packed {
    logic [FIELD_W-1:0] cur;
    logic [FIELD_W-1:0] best;
  } dp_out_t;

endpackage
`default_nettype wire

// ----- hdl/lsq_ram.sv -----
`default_nettype none
module lsq_ram #(
  parameter int Width = 8,
  parameter int Depth = 64
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_q <= mem[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule
`default_nettype wire

// ----- hdl/lsq_dp.sv -----
`default_nettype none
// One square-side step: min of the three neighbours plus one, or zero on a clear bit.
module lsq_dp (
  input  wire lsq_pkg::dp_in_t  dp_i,
  output lsq_pkg::dp_out_t      dp_o
);

  logic [lsq_pkg::FIELD_W-1:0] m1;
  logic [lsq_pkg::FIELD_W-1:0] m2;
  logic [lsq_pkg::FIELD_W-1:0] cur;

  always_comb begin
    m1  = (dp_i.up < dp_i.left) ? dp_i.up : dp_i.left;
    m2  = (m1 < dp_i.diag) ? m1 : dp_i.diag;
    cur = dp_i.is_one ? (m2 + lsq_pkg::FIELD_W'(1)) : '0;
    dp_o.cur  = cur;
    dp_o.best = (cur > dp_i.best) ? cur : dp_i.best;
  end

endmodule
`default_nettype wire

// ----- hdl/largest_ones_square_query.sv -----
`default_nettype none
// Largest all-ones square in a rectangle of a toggleable bit matrix. The matrix sits in a
// row-wide RAM (one row per word) cleared at reset by per-row valid bits, so no clearing
// pass is needed. A toggle beat reads the row, flips the bit and writes the row back.
// A query beat sweeps the clipped rectangle row by row; each row is fetched in S_ROW_RD and
// S_ROW_WAIT, and each column takes S_COL_RD and then S_COL_CALC, because a single
// dynamic-programming step unit reads the previous row's side from a column RAM and writes
// the new side back to the same address. After the sweep the result is offered on the
// output register. The block takes no new beat while an item is at work.
module largest_ones_square_query (
  input  wire  logic                            clk_i,
  input  wire  logic                            rst_ni,
  input  wire  logic                            cfg_we_i,
  input  wire  logic [lsq_pkg::CFG_IDX_W-1:0]   cfg_index_i,
  input  wire  logic [lsq_pkg::FIELD_W-1:0]     cfg_data_i,
  input  wire  logic                            in_valid_i,
  output logic                                  in_ready_o,
  input  wire  logic                            func_i,
  input  wire  logic [lsq_pkg::FIELD_W-1:0]     row_first_i,
  input  wire  logic [lsq_pkg::FIELD_W-1:0]     col_first_i,
  input  wire  logic [lsq_pkg::FIELD_W-1:0]     row_last_i,
  input  wire  logic [lsq_pkg::FIELD_W-1:0]     col_last_i,
  output logic                                  out_valid_o,
  input  wire  logic                            out_ready_i,
  output logic [lsq_pkg::FIELD_W-1:0]           square_side_o
);

  localparam int FW = lsq_pkg::FIELD_W;
  localparam logic [FW-1:0] ONE = FW'(1);
  localparam logic [FW-1:0] ROWS_F = FW'(lsq_pkg::ROWS);
  localparam logic [FW-1:0] COLS_F = FW'(lsq_pkg::COLS);

  lsq_pkg::state_e state_q, state_d;

  logic [FW-1:0] rows_used_q, cols_used_q;
  logic [FW-1:0] row_q, row_d, col_q, col_d;
  logic [FW-1:0] c1_q, c1_d, c2_q, c2_d, r2_q, r2_d;
  logic [FW-1:0] left_q, left_d, diag_q, diag_d, best_q, best_d;
  logic          first_row_q, first_row_d;
  logic [lsq_pkg::COLS-1:0] row_word_q, row_word_d;
  logic [lsq_pkg::ROWS-1:0] row_valid_q, row_valid_d;
  logic          out_valid_q, out_valid_d;
  logic [FW-1:0] side_q, side_d;

  logic [FW-1:0] nr, nc, r1c, c1c, r2c, c2c;
  logic [FW-1:0] row_m1, col_m1;
  logic [lsq_pkg::ROW_AW-1:0] row_idx;
  logic [lsq_pkg::COL_AW-1:0] col_idx;
  logic          accept, tgl_ok, qry_ok;

  logic                     cell_we;
  logic [lsq_pkg::COLS-1:0] cell_rdata, cell_word, cell_wdata;
  logic                     dp_we;
  logic [FW-1:0]            dp_rdata;
  lsq_pkg::dp_in_t          dp_in;
  lsq_pkg::dp_out_t         dp_out;

  // Effective used area, clamped to the array.
  always_comb begin
    nr = (rows_used_q == '0) ? ONE : ((rows_used_q > ROWS_F) ? ROWS_F : rows_used_q);
    nc = (cols_used_q == '0) ? ONE : ((cols_used_q > COLS_F) ? COLS_F : cols_used_q);
    r1c = (row_first_i == '0) ? ONE : row_first_i;
    c1c = (col_first_i == '0) ? ONE : col_first_i;
    r2c = (row_last_i > nr) ? nr : row_last_i;
    c2c = (col_last_i > nc) ? nc : col_last_i;
  end

  assign in_ready_o = (state_q == lsq_pkg::S_IDLE);
  assign accept     = in_valid_i && in_ready_o;
  assign tgl_ok     = (row_first_i != '0) && (row_first_i <= nr) &&
                      (col_first_i != '0) && (col_first_i <= nc);
  assign qry_ok     = (r1c <= r2c) && (c1c <= c2c);

  assign row_m1  = row_q - ONE;
  assign col_m1  = col_q - ONE;
  assign row_idx = row_m1[lsq_pkg::ROW_AW-1:0];
  assign col_idx = col_m1[lsq_pkg::COL_AW-1:0];

  // A row never written reads as all zero.
  assign cell_word  = row_valid_q[row_idx] ? cell_rdata : '0;
  assign cell_wdata = cell_word ^ (lsq_pkg::COLS'(1) << col_idx);
  assign cell_we    = (state_q == lsq_pkg::S_TGL_WR);
  assign dp_we      = (state_q == lsq_pkg::S_COL_CALC);

  lsq_ram #(.Width(lsq_pkg::COLS), .Depth(lsq_pkg::ROWS)) u_cell_ram (
    .clk_i   (clk_i),
    .we_i    (cell_we),
    .waddr_i (row_idx),
    .wdata_i (cell_wdata),
    .raddr_i (row_idx),
    .rdata_o (cell_rdata)
  );

  lsq_ram #(.Width(FW), .Depth(lsq_pkg::COLS)) u_side_ram (
    .clk_i   (clk_i),
    .we_i    (dp_we),
    .waddr_i (col_idx),
    .wdata_i (dp_out.cur),
    .raddr_i (col_idx),
    .rdata_o (dp_rdata)
  );

  // The first row of a query sees an all-zero row above it.
  always_comb begin
    dp_in.is_one = row_word_q[col_idx];
    dp_in.up     = first_row_q ? '0 : dp_rdata;
    dp_in.left   = left_q;
    dp_in.diag   = diag_q;
    dp_in.best   = best_q;
  end

  lsq_dp u_dp (
    .dp_i (dp_in),
    .dp_o (dp_out)
  );

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      lsq_pkg::S_IDLE: begin
        if (accept) begin
          if (func_i == lsq_pkg::FUNC_TOGGLE) begin
            state_d = tgl_ok ? lsq_pkg::S_TGL_RD : lsq_pkg::S_IDLE;
          end else begin
            state_d = qry_ok ? lsq_pkg::S_ROW_RD : lsq_pkg::S_DONE;
          end
        end
      end
      lsq_pkg::S_TGL_RD:   state_d = lsq_pkg::S_TGL_WR;
      lsq_pkg::S_TGL_WR:   state_d = lsq_pkg::S_IDLE;
      lsq_pkg::S_ROW_RD:   state_d = lsq_pkg::S_ROW_WAIT;
      lsq_pkg::S_ROW_WAIT: state_d = lsq_pkg::S_COL_RD;
      lsq_pkg::S_COL_RD:   state_d = lsq_pkg::S_COL_CALC;
      lsq_pkg::S_COL_CALC: begin
        if (col_q != c2_q) begin
          state_d = lsq_pkg::S_COL_RD;
        end else if (row_q != r2_q) begin
          state_d = lsq_pkg::S_ROW_RD;
        end else begin
          state_d = lsq_pkg::S_DONE;
        end
      end
      lsq_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          state_d = lsq_pkg::S_IDLE;
        end
      end
      default: state_d = lsq_pkg::S_IDLE;
    endcase
  end

  // Datapath and output updates.
  always_comb begin
    row_d       = row_q;
    col_d       = col_q;
    c1_d        = c1_q;
    c2_d        = c2_q;
    r2_d        = r2_q;
    left_d      = left_q;
    diag_d      = diag_q;
    best_d      = best_q;
    first_row_d = first_row_q;
    row_word_d  = row_word_q;
    row_valid_d = row_valid_q;
    out_valid_d = out_valid_q && !out_ready_i;
    side_d      = side_q;
    unique case (state_q)
      lsq_pkg::S_IDLE: begin
        if (accept) begin
          row_d       = (func_i == lsq_pkg::FUNC_QUERY) ? r1c : row_first_i;
          col_d       = col_first_i;
          c1_d        = c1c;
          c2_d        = c2c;
          r2_d        = r2c;
          best_d      = '0;
          first_row_d = 1'b1;
        end
      end
      lsq_pkg::S_TGL_WR: begin
        row_valid_d[row_idx] = 1'b1;
      end
      lsq_pkg::S_ROW_WAIT: begin
        row_word_d = cell_word;
        col_d      = c1_q;
        left_d     = '0;
        diag_d     = '0;
      end
      lsq_pkg::S_COL_CALC: begin
        left_d = dp_out.cur;
        diag_d = dp_in.up;
        best_d = dp_out.best;
        if (col_q != c2_q) begin
          col_d = col_q + ONE;
        end else begin
          row_d       = row_q + ONE;
          first_row_d = 1'b0;
        end
      end
      lsq_pkg::S_DONE: begin
        if (!out_valid_q || out_ready_i) begin
          out_valid_d = 1'b1;
          side_d      = best_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= lsq_pkg::S_IDLE;
      rows_used_q <= ROWS_F;
      cols_used_q <= COLS_F;
      row_valid_q <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_valid_q <= row_valid_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          lsq_pkg::CFG_ROWS_USED: rows_used_q <= cfg_data_i;
          lsq_pkg::CFG_COLS_USED: cols_used_q <= cfg_data_i;
          default: begin
          end
        endcase
      end
    end
  end

  // Payload registers: no reset.
  always_ff @(posedge clk_i) begin
    row_q       <= row_d;
    col_q       <= col_d;
    c1_q        <= c1_d;
    c2_q        <= c2_d;
    r2_q        <= r2_d;
    left_q      <= left_d;
    diag_q      <= diag_d;
    best_q      <= best_d;
    first_row_q <= first_row_d;
    row_word_q  <= row_word_d;
    side_q      <= side_d;
  end

  assign out_valid_o   = out_valid_q;
  assign square_side_o = side_q;

  a_calc_after_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsq_pkg::S_COL_CALC) |-> ($past(state_q) == lsq_pkg::S_COL_RD))
    else $error("column step without a preceding side read");

  a_col_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsq_pkg::S_COL_CALC) |-> ((col_q >= c1_q) && (col_q <= c2_q)))
    else $error("column cursor left the query rectangle");

  a_best_bounded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == lsq_pkg::S_DONE) |-> (best_q <= COLS_F))
    else $error("square side beyond the column count");

endmodule
`default_nettype wire
